// ----- rtl/ltt_pkg.sv -----
`default_nettype none

package ltt_pkg;

  localparam int LENGTH_BITS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [1:0] KIND_TEXT      = 2'd0;
  localparam logic [1:0] KIND_END_TOKEN = 2'd1;
  localparam logic [1:0] KIND_BRACKET   = 2'd2;
  localparam logic [1:0] KIND_END_INPUT = 2'd3;

  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_LBRACE = 8'h7B;
  localparam logic [7:0] CHAR_RBRACE = 8'h7D;
  localparam logic [7:0] CHAR_LBRACK = 8'h5B;
  localparam logic [7:0] CHAR_RBRACK = 8'h5D;
  localparam logic [7:0] CHAR_SEMI   = 8'h3B;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;
  localparam logic [7:0] CHAR_COLON  = 8'h3A;
  localparam logic [7:0] CHAR_EQUAL  = 8'h3D;
  localparam logic [7:0] CHAR_DQUOTE = 8'h22;
  localparam logic [7:0] CHAR_SQUOTE = 8'h27;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  value;
    logic        first;
    logic        quoted;
    logic [15:0] token_length;
  } out_item_t;

  // Work for the back end: up to four results, emitted in the order
  // text, end of token, bracket, end of input.
  typedef struct packed {
    logic        has_text;
    logic        text_first;
    logic        text_quoted;
    logic        has_close;
    logic        close_quoted;
    logic [15:0] close_len;
    logic        has_bracket;
    logic        has_end;
    logic [7:0]  char_byte;
  } op_t;

endpackage

`default_nettype wire

// ----- rtl/ltt_front.sv -----
`default_nettype none

module ltt_front #(
  parameter int LENGTH_BITS = ltt_pkg::LENGTH_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_accept,
  input  wire ltt_pkg::in_item_t in_item,
  output logic                  q_push,
  output ltt_pkg::op_t          q_op
);

  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_BARE   = 2'd1;
  localparam logic [1:0] MODE_QUOTED = 2'd2;

  localparam logic [LENGTH_BITS-1:0] CNT_MAX = {LENGTH_BITS{1'b1}};
  localparam logic [LENGTH_BITS-1:0] CNT_ONE = LENGTH_BITS'(1);

  logic [1:0]             mode_r, mode_nxt, mode_mid;
  logic                   single_r, single_nxt, single_mid;
  logic [LENGTH_BITS-1:0] cnt_r, cnt_nxt, cnt_mid, cnt_inc;
  logic [7:0]             c;
  logic                   is_ws, is_sep, is_quote, is_bracket, is_match;
  ltt_pkg::op_t           op;

  function automatic logic [15:0] len_out(input logic [LENGTH_BITS-1:0] v);
    logic [32:0] w;
    w = 33'(v);
    if (w > 33'h0FFFF) begin
      return 16'hFFFF;
    end
    return w[15:0];
  endfunction

  assign c          = in_item.in_byte;
  assign is_ws      = (c <= ltt_pkg::CHAR_SPACE);
  assign is_sep     = (c == ltt_pkg::CHAR_COMMA) || (c == ltt_pkg::CHAR_COLON) ||
                      (c == ltt_pkg::CHAR_SEMI) || (c == ltt_pkg::CHAR_EQUAL);
  assign is_quote   = (c == ltt_pkg::CHAR_DQUOTE) || (c == ltt_pkg::CHAR_SQUOTE);
  assign is_bracket = (c == ltt_pkg::CHAR_LBRACE) || (c == ltt_pkg::CHAR_RBRACE) ||
                      (c == ltt_pkg::CHAR_LBRACK) || (c == ltt_pkg::CHAR_RBRACK);
  assign is_match   = single_r ? (c == ltt_pkg::CHAR_SQUOTE) : (c == ltt_pkg::CHAR_DQUOTE);
  assign cnt_inc    = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + CNT_ONE;

  always_comb begin
    op         = '0;
    mode_mid   = mode_r;
    single_mid = single_r;
    cnt_mid    = cnt_r;
    mode_nxt   = mode_r;
    single_nxt = single_r;
    cnt_nxt    = cnt_r;
    if (c == 8'd0) begin
      op.has_close    = (mode_r == MODE_BARE) || (mode_r == MODE_QUOTED);
      op.close_quoted = (mode_r == MODE_QUOTED);
      op.close_len    = len_out(cnt_r);
      op.has_end      = 1'b1;
      mode_nxt        = MODE_IDLE;
      single_nxt      = 1'b0;
      cnt_nxt         = '0;
    end else begin
      unique case (mode_r)
        MODE_QUOTED: begin
          if (is_match) begin
            op.has_close    = 1'b1;
            op.close_quoted = 1'b1;
            op.close_len    = len_out(cnt_r);
            mode_mid        = MODE_IDLE;
            single_mid      = 1'b0;
            cnt_mid         = '0;
          end else begin
            op.has_text    = 1'b1;
            op.text_first  = (cnt_r == '0);
            op.text_quoted = 1'b1;
            op.char_byte   = c;
            cnt_mid        = cnt_inc;
          end
        end
        MODE_BARE: begin
          if (is_ws || is_sep || is_quote || is_bracket) begin
            op.has_close   = 1'b1;
            op.close_len   = len_out(cnt_r);
            op.has_bracket = is_bracket;
            op.char_byte   = c;
            mode_mid       = MODE_IDLE;
            single_mid     = 1'b0;
            cnt_mid        = '0;
          end else begin
            op.has_text  = 1'b1;
            op.char_byte = c;
            cnt_mid      = cnt_inc;
          end
        end
        default: begin
          mode_mid = MODE_IDLE;
          priority if (is_ws || is_sep) begin
            mode_mid = MODE_IDLE;
          end else if (is_bracket) begin
            op.has_bracket = 1'b1;
            op.char_byte   = c;
          end else if (is_quote) begin
            mode_mid   = MODE_QUOTED;
            single_mid = (c == ltt_pkg::CHAR_SQUOTE);
            cnt_mid    = '0;
          end else begin
            mode_mid      = MODE_BARE;
            single_mid    = 1'b0;
            cnt_mid       = CNT_ONE;
            op.has_text   = 1'b1;
            op.text_first = 1'b1;
            op.char_byte  = c;
          end
        end
      endcase
      mode_nxt   = mode_mid;
      single_nxt = single_mid;
      cnt_nxt    = cnt_mid;
      if (in_item.last) begin
        if ((mode_mid == MODE_BARE) || (mode_mid == MODE_QUOTED)) begin
          op.has_close    = 1'b1;
          op.close_quoted = (mode_mid == MODE_QUOTED);
          op.close_len    = len_out(cnt_mid);
        end
        op.has_end      = 1'b1;
        mode_nxt        = MODE_IDLE;
        single_nxt      = 1'b0;
        cnt_nxt         = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      single_r <= 1'b0;
      cnt_r    <= '0;
    end else if (in_accept) begin
      mode_r   <= mode_nxt;
      single_r <= single_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  assign q_op   = op;
  assign q_push = in_accept && (op.has_text || op.has_close || op.has_bracket || op.has_end);

endmodule

`default_nettype wire

// ----- rtl/ltt_queue.sv -----
`default_nettype none

module ltt_queue #(
  parameter int DEPTH = ltt_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         wr_en,
  input  wire ltt_pkg::op_t wr_op,
  output logic              q_full,
  input  wire logic         rd_en,
  output logic              rd_valid,
  output ltt_pkg::op_t      rd_op
);

  localparam int PTR_BITS = $clog2(DEPTH);
  localparam int CNT_BITS = $clog2(DEPTH + 1);
  localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
  localparam logic [PTR_BITS-1:0] PTR_ONE  = PTR_BITS'(1);
  localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);
  localparam logic [CNT_BITS-1:0] CNT_ONE  = CNT_BITS'(1);

  ltt_pkg::op_t          entries_r [DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_BITS-1:0]   count_r;

  assign q_full   = (count_r == CNT_FULL);
  assign rd_valid = (count_r != '0);
  assign rd_op    = entries_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries_r[wr_ptr_r] <= wr_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_ONE;
      end
      if (rd_en) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_ONE;
      end
      if (wr_en && !rd_en) begin
        count_r <= count_r + CNT_ONE;
      end else if (rd_en && !wr_en) begin
        count_r <= count_r - CNT_ONE;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ltt_back.sv -----
`default_nettype none

module ltt_back (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         head_valid,
  input  wire ltt_pkg::op_t head_op,
  output logic              head_pop,
  input  wire logic         out_pop,
  output logic              out_empty,
  output ltt_pkg::out_item_t out_item
);

  logic [3:0]         sent_r, sent_nxt, pending, sel, remaining;
  logic               out_valid_r, advance, emit;
  ltt_pkg::out_item_t out_item_r, item_nxt;

  assign pending = {head_op.has_end, head_op.has_bracket,
                    head_op.has_close, head_op.has_text} & ~sent_r;
  assign advance = !out_valid_r || out_pop;
  assign emit    = head_valid && advance;

  always_comb begin
    sel      = 4'b0000;
    item_nxt = '0;
    priority if (pending[0]) begin
      sel             = 4'b0001;
      item_nxt.kind   = ltt_pkg::KIND_TEXT;
      item_nxt.value  = head_op.char_byte;
      item_nxt.first  = head_op.text_first;
      item_nxt.quoted = head_op.text_quoted;
    end else if (pending[1]) begin
      sel                   = 4'b0010;
      item_nxt.kind         = ltt_pkg::KIND_END_TOKEN;
      item_nxt.quoted       = head_op.close_quoted;
      item_nxt.token_length = head_op.close_len;
    end else if (pending[2]) begin
      sel            = 4'b0100;
      item_nxt.kind  = ltt_pkg::KIND_BRACKET;
      item_nxt.value = head_op.char_byte;
    end else begin
      sel           = 4'b1000;
      item_nxt.kind = ltt_pkg::KIND_END_INPUT;
    end
  end

  assign remaining = pending & ~sel;
  assign head_pop  = emit && (remaining == 4'b0000);
  assign sent_nxt  = head_pop ? 4'b0000 : (sent_r | sel);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sent_r      <= 4'b0000;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        sent_r <= sent_nxt;
      end
      if (advance) begin
        out_valid_r <= head_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item_r <= item_nxt;
    end
  end

  assign out_empty = !out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

// ----- rtl/lua_table_tokenizer_unit.sv -----
// The result beats of a byte pass through the queue and then the output register before they are offered.
// One byte per cycle goes in while the queue is not full; the result side moves one beat per
// cycle while the receiver keeps popping, so a byte with k results takes k beats and a skipped byte takes none.
// The queue between the classifier and the result sequencer absorbs bursts of multi-beat bytes.
// Reset clears the scan mode, the length count, the queue and the output valid flag.
`default_nettype none

module lua_table_tokenizer_unit #(
  parameter int LENGTH_BITS = ltt_pkg::LENGTH_BITS_DEF,
  parameter int QUEUE_DEPTH = ltt_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  output logic                    full,
  input  wire ltt_pkg::in_item_t  in_item,
  output logic                    empty,
  input  wire logic               pop,
  output ltt_pkg::out_item_t      out_item
);

  logic         in_accept, q_push, q_full, q_pop, q_valid;
  ltt_pkg::op_t q_op, head_op;

  assign full      = q_full;
  assign in_accept = push && !q_full;

  ltt_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_item   (in_item),
    .q_push    (q_push),
    .q_op      (q_op)
  );

  ltt_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (q_push),
    .wr_op    (q_op),
    .q_full   (q_full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_op    (head_op)
  );

  ltt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_valid),
    .head_op    (head_op),
    .head_pop   (q_pop),
    .out_pop    (pop),
    .out_empty  (empty),
    .out_item   (out_item)
  );

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  a_pop_has_head: assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
    else $error("back end released an entry that was not there");

  a_first_text_only: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_item.first) |-> (out_item.kind == ltt_pkg::KIND_TEXT))
    else $error("first flag on a beat that is not token text");

  a_plain_kinds: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_item.kind == ltt_pkg::KIND_BRACKET ||
                out_item.kind == ltt_pkg::KIND_END_INPUT)) |->
    (!out_item.quoted && out_item.token_length == 16'd0))
    else $error("bracket or end of input beat carries token fields");

endmodule

`default_nettype wire

// ----- dv/lua_table_tokenizer_checker.sv -----
`timescale 1ns / 100ps

module lua_table_tokenizer_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic               full,
  input  ltt_pkg::in_item_t  in_item,
  input  logic               empty,
  input  logic               pop,
  input  ltt_pkg::out_item_t out_item,
  output int                 mismatches,
  output int                 pending,
  output int                 results_seen
);

  typedef enum logic [1:0] {
    SCAN_IDLE   = 2'd0,
    SCAN_BARE   = 2'd1,
    SCAN_QUOTED = 2'd2
  } scan_e;

  scan_e              scan;
  logic               quote_single;
  logic [15:0]        tok_len;
  ltt_pkg::out_item_t token_beats_due[$];
  int                 n_bad;
  int                 n_results;

  task automatic due_beat(input logic [1:0] k, input logic [7:0] v, input logic f,
                          input logic q, input logic [15:0] len);
    ltt_pkg::out_item_t b;
    b.kind         = k;
    b.value        = v;
    b.first        = f;
    b.quoted       = q;
    b.token_length = len;
    token_beats_due.push_back(b);
  endtask

  task automatic close_token();
    if (scan == SCAN_BARE || scan == SCAN_QUOTED) begin
      due_beat(ltt_pkg::KIND_END_TOKEN, 8'h00, 1'b0, scan == SCAN_QUOTED, tok_len);
    end
    scan         = SCAN_IDLE;
    tok_len      = '0;
    quote_single = 1'b0;
  endtask

  task automatic bump_len();
    if (tok_len != 16'hFFFF) begin
      tok_len = tok_len + 16'd1;
    end
  endtask

  task automatic tokenize_byte(input ltt_pkg::in_item_t it);
    logic [7:0] c;
    logic       brk;
    logic       sep;
    logic       quote;
    c     = it.in_byte;
    brk   = (c == ltt_pkg::CHAR_LBRACE) || (c == ltt_pkg::CHAR_RBRACE) ||
            (c == ltt_pkg::CHAR_LBRACK) || (c == ltt_pkg::CHAR_RBRACK);
    sep   = (c == ltt_pkg::CHAR_COMMA) || (c == ltt_pkg::CHAR_COLON) ||
            (c == ltt_pkg::CHAR_SEMI) || (c == ltt_pkg::CHAR_EQUAL);
    quote = (c == ltt_pkg::CHAR_DQUOTE) || (c == ltt_pkg::CHAR_SQUOTE);
    if (c == 8'h00) begin
      close_token();
      due_beat(ltt_pkg::KIND_END_INPUT, 8'h00, 1'b0, 1'b0, 16'd0);
    end else begin
      case (scan)
        SCAN_QUOTED: begin
          if (c == (quote_single ? ltt_pkg::CHAR_SQUOTE : ltt_pkg::CHAR_DQUOTE)) begin
            close_token();
          end else begin
            due_beat(ltt_pkg::KIND_TEXT, c, tok_len == 16'd0, 1'b1, 16'd0);
            bump_len();
          end
        end
        SCAN_BARE: begin
          if (c <= ltt_pkg::CHAR_SPACE || sep || quote) begin
            close_token();
          end else if (brk) begin
            close_token();
            due_beat(ltt_pkg::KIND_BRACKET, c, 1'b0, 1'b0, 16'd0);
          end else begin
            due_beat(ltt_pkg::KIND_TEXT, c, 1'b0, 1'b0, 16'd0);
            bump_len();
          end
        end
        default: begin
          scan = SCAN_IDLE;
          if (brk) begin
            due_beat(ltt_pkg::KIND_BRACKET, c, 1'b0, 1'b0, 16'd0);
          end else if (quote) begin
            scan         = SCAN_QUOTED;
            quote_single = (c == ltt_pkg::CHAR_SQUOTE);
            tok_len      = '0;
          end else if (c > ltt_pkg::CHAR_SPACE && !sep) begin
            scan         = SCAN_BARE;
            quote_single = 1'b0;
            tok_len      = '0;
            due_beat(ltt_pkg::KIND_TEXT, c, 1'b1, 1'b0, 16'd0);
            bump_len();
          end
        end
      endcase
      if (it.last) begin
        close_token();
        due_beat(ltt_pkg::KIND_END_INPUT, 8'h00, 1'b0, 1'b0, 16'd0);
      end
    end
  endtask

  always @(posedge clk) begin : watch
    ltt_pkg::out_item_t want;
    if (!rst_n) begin
      scan         = SCAN_IDLE;
      quote_single = 1'b0;
      tok_len      = '0;
      n_bad        = 0;
      n_results    = 0;
      token_beats_due.delete();
    end else begin
      if (push && !full) begin
        tokenize_byte(in_item);
      end
      if (pop && !empty) begin
        n_results++;
        if (token_beats_due.size() == 0) begin
          n_bad++;
          if (n_bad <= 10) begin
            $display("%t: result beat with none expected: kind=%0d value=%02h",
                     $realtime, out_item.kind, out_item.value);
            $display("%t:   first=%0b quoted=%0b len=%0d", $realtime, out_item.first,
                     out_item.quoted, out_item.token_length);
          end
        end else begin
          want = token_beats_due.pop_front();
          if (out_item.kind !== want.kind || out_item.value !== want.value ||
              out_item.first !== want.first || out_item.quoted !== want.quoted ||
              out_item.token_length !== want.token_length) begin
            n_bad++;
            if (n_bad <= 10) begin
              $display("%t: result beat %0d expected kind=%0d value=%02h first=%0b",
                       $realtime, n_results, want.kind, want.value, want.first);
              $display("%t:   expected quoted=%0b len=%0d", $realtime, want.quoted,
                       want.token_length);
              $display("%t: result beat %0d actual   kind=%0d value=%02h first=%0b",
                       $realtime, n_results, out_item.kind, out_item.value,
                       out_item.first);
              $display("%t:   actual   quoted=%0b len=%0d", $realtime, out_item.quoted,
                       out_item.token_length);
            end
          end
        end
      end
    end
    mismatches   <= n_bad;
    pending      <= token_beats_due.size();
    results_seen <= n_results;
  end

endmodule

// ----- dv/tb_lua_table_tokenizer_unit.sv -----
`timescale 1ns / 100ps

module tb_lua_table_tokenizer_unit;

  localparam int RX_HOLD_CYCLES = 150;

  logic               clk;
  logic               rst_n;
  logic               push;
  logic               full;
  ltt_pkg::in_item_t  in_item;
  logic               empty;
  logic               pop;
  ltt_pkg::out_item_t out_item;

  int tx_idle;
  int rx_stall;
  bit hold_rx;
  int n_bytes;
  int n_random;
  int mismatches;
  int pending;
  int results_seen;

  lua_table_tokenizer_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

  lua_table_tokenizer_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_item      (in_item),
    .empty        (empty),
    .pop          (pop),
    .out_item     (out_item),
    .mismatches   (mismatches),
    .pending      (pending),
    .results_seen (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("lua_table_tokenizer_unit regression: fail");
    $finish;
  end

  initial begin
    pop = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_rx) begin
        pop <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        hold_rx = 1'b0;
      end
      pop <= ($urandom_range(1, 100) > rx_stall);
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit l, input bit counted);
    while ($urandom_range(1, 100) <= tx_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    in_item <= '{in_byte: b, last: l};
    do @(posedge clk); while (full);
    n_bytes++;
    if (counted) begin
      n_random++;
    end
  endtask

  function automatic logic [7:0] bare_char();
    logic [7:0] c;
    c = 8'($urandom_range(33, 255));
    if (c == ltt_pkg::CHAR_LBRACE || c == ltt_pkg::CHAR_RBRACE ||
        c == ltt_pkg::CHAR_LBRACK || c == ltt_pkg::CHAR_RBRACK ||
        c == ltt_pkg::CHAR_COMMA || c == ltt_pkg::CHAR_COLON ||
        c == ltt_pkg::CHAR_SEMI || c == ltt_pkg::CHAR_EQUAL ||
        c == ltt_pkg::CHAR_DQUOTE || c == ltt_pkg::CHAR_SQUOTE) begin
      c = 8'h41 + 8'($urandom_range(0, 25));
    end
    return c;
  endfunction

  function automatic logic [7:0] bracket_char();
    case ($urandom_range(0, 3))
      0:       return ltt_pkg::CHAR_LBRACE;
      1:       return ltt_pkg::CHAR_RBRACE;
      2:       return ltt_pkg::CHAR_LBRACK;
      default: return ltt_pkg::CHAR_RBRACK;
    endcase
  endfunction

  task automatic send_text();
    logic [7:0] q;
    logic [7:0] c;
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(0, 5))
        0: send_byte(bracket_char(), 1'b0, 1'b1);
        1: begin
          case ($urandom_range(0, 5))
            0:       c = ltt_pkg::CHAR_COMMA;
            1:       c = ltt_pkg::CHAR_COLON;
            2:       c = ltt_pkg::CHAR_SEMI;
            3:       c = ltt_pkg::CHAR_EQUAL;
            4:       c = ltt_pkg::CHAR_SPACE;
            default: c = 8'($urandom_range(1, 32));
          endcase
          send_byte(c, 1'b0, 1'b0);
        end
        2, 3: begin
          repeat ($urandom_range(1, 6)) send_byte(bare_char(), 1'b0, 1'b1);
          if ($urandom_range(0, 3) == 0) begin
            send_byte($urandom_range(0, 1) ? ltt_pkg::CHAR_SQUOTE : ltt_pkg::CHAR_DQUOTE,
                      1'b0, 1'b1);
          end
        end
        default: begin
          q = $urandom_range(0, 1) ? ltt_pkg::CHAR_SQUOTE : ltt_pkg::CHAR_DQUOTE;
          send_byte(q, 1'b0, 1'b1);
          repeat ($urandom_range(0, 6)) begin
            c = 8'($urandom_range(1, 255));
            if (c == q) begin
              c = ltt_pkg::CHAR_SPACE;
            end
            send_byte(c, 1'b0, 1'b1);
          end
          send_byte(q, 1'b0, 1'b1);
        end
      endcase
    end
    case ($urandom_range(0, 3))
      0:       send_byte(8'h00, 1'b0, 1'b1);
      1:       send_byte(bracket_char(), 1'b1, 1'b1);
      2:       send_byte(bare_char(), 1'b1, 1'b1);
      default: send_byte(8'($urandom_range(1, 255)), 1'b1, 1'b1);
    endcase
  endtask

  task automatic run_random(input int goal);
    int stop_at;
    stop_at = n_random + goal;
    while (n_random < stop_at) begin
      if ($urandom_range(0, 4) != 0) begin
        send_text();
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0, 1'b1);
        end
      end
    end
  endtask

  initial begin
    rst_n    = 1'b0;
    push     = 1'b0;
    in_item  = '0;
    tx_idle  = 0;
    rx_stall = 0;
    hold_rx  = 1'b0;
    n_bytes  = 0;
    n_random = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed text covering skips, brackets, both quote styles and every way a token ends other than whitespace.
    send_byte(8'h01, 1'b0, 1'b0);
    send_byte(ltt_pkg::CHAR_SPACE, 1'b0, 1'b0);
    send_byte(ltt_pkg::CHAR_LBRACE, 1'b0, 1'b0);
    send_byte(8'h61, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(ltt_pkg::CHAR_RBRACE, 1'b0, 1'b0);
    send_byte(ltt_pkg::CHAR_DQUOTE, 1'b0, 1'b0);
    send_byte(ltt_pkg::CHAR_SQUOTE, 1'b0, 1'b0);
    send_byte(ltt_pkg::CHAR_LBRACK, 1'b0, 1'b0);
    send_byte(8'h01, 1'b0, 1'b0);
    send_byte(ltt_pkg::CHAR_SEMI, 1'b0, 1'b0);
    send_byte(ltt_pkg::CHAR_DQUOTE, 1'b0, 1'b0);
    send_byte(ltt_pkg::CHAR_SQUOTE, 1'b0, 1'b0);
    send_byte(ltt_pkg::CHAR_SQUOTE, 1'b0, 1'b0);
    send_byte(8'h7F, 1'b0, 1'b0);
    send_byte(ltt_pkg::CHAR_COMMA, 1'b0, 1'b0);
    send_byte(ltt_pkg::CHAR_EQUAL, 1'b0, 1'b0);
    send_byte(ltt_pkg::CHAR_COLON, 1'b0, 1'b0);
    send_byte(8'h6B, 1'b0, 1'b0);
    send_byte(ltt_pkg::CHAR_SQUOTE, 1'b0, 1'b0);
    send_byte(8'h7A, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(ltt_pkg::CHAR_DQUOTE, 1'b0, 1'b0);
    send_byte(8'h71, 1'b1, 1'b0);
    send_byte(8'h80, 1'b1, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(ltt_pkg::CHAR_SQUOTE, 1'b0, 1'b0);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(ltt_pkg::CHAR_RBRACK, 1'b1, 1'b0);

    run_random(70);

    hold_rx = 1'b1;
    run_random(40);

    tx_idle = 81;
    run_random(70);

    tx_idle  = 0;
    rx_stall = 81;
    run_random(70);

    tx_idle  = 25;
    rx_stall = 25;
    run_random(70);

    push <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d text bytes (%0d from random texts and noise) under four idle mixes",
             n_bytes, n_random);
    $display("and a long receiver hold, and checked %0d result beats.", results_seen);
    if (mismatches == 0) begin
      $display("lua_table_tokenizer_unit regression: pass");
    end else begin
      $display("lua_table_tokenizer_unit regression: fail");
    end
    $finish;
  end

endmodule
